FILE: design/apq_pkg.sv
// Shared types, codes and widths for the aging priority queue.
package apq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 256;

  localparam int TIME_W  = 30;
  localparam int SEV_W   = 30;
  localparam int NAME_W  = 48;
  localparam int ORDER_W = 32;
  localparam int GAIN_W  = 24;
  localparam int WAIT_W  = TIME_W + 1;
  localparam int PROD_W  = WAIT_W + GAIN_W + 1;
  localparam int PRI_W   = PROD_W + 1;

  // Request codes.
  localparam logic [1:0] REQ_ARRIVE = 2'd0;
  localparam logic [1:0] REQ_SERVE  = 2'd1;
  localparam logic [1:0] REQ_LEAVE  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_SERVED   = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_LEFT     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TIME_W-1:0] time_now;
    logic [NAME_W-1:0] name_code;
    logic [SEV_W-1:0]  severity;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [NAME_W-1:0] served_name;
  } rsp_t;

  // One stored slot.
  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  arrival;
    logic [SEV_W-1:0]   severity;
    logic [NAME_W-1:0]  name;
    logic [ORDER_W-1:0] order;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic cand_valid;
  } eval_ctrl_t;

  typedef struct packed {
    logic              found;
    logic              busy;
    logic [NAME_W-1:0] name;
  } eval_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WRITE
  } state_t;

endpackage

FILE: design/apq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/apq_eval.sv
// Shared evaluation unit: scores one slot a cycle and keeps the best so far.
module apq_eval
  import apq_pkg::*;
#(
  parameter int AW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  eval_ctrl_t         ctrl,
  input  logic [1:0]         req_type,
  input  logic [TIME_W-1:0]  time_now,
  input  logic [NAME_W-1:0]  req_name,
  input  logic [GAIN_W-1:0]  gain,
  input  logic [ORDER_W-1:0] counter,
  input  logic [AW-1:0]      cand_addr,
  input  entry_t             cand,
  output eval_res_t          res,
  output logic [AW-1:0]      best_addr
);

  logic signed [WAIT_W-1:0]   wait_val;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   prod;

  // Stage register between the multiplier and the comparator.
  logic                       s_valid;
  logic [AW-1:0]              s_addr;
  logic                       s_slot_valid;
  logic signed [PROD_W-1:0]   s_prod;
  logic [SEV_W-1:0]           s_sev;
  logic [NAME_W-1:0]          s_name;
  logic [ORDER_W-1:0]         s_age;

  logic                       have;
  logic signed [PRI_W-1:0]    best_pri;
  logic [NAME_W-1:0]          best_name;
  logic [ORDER_W-1:0]         best_age;

  logic signed [PRI_W-1:0]    pri;
  logic                       eligible;
  logic                       better;

  assign wait_val = $signed({1'b0, time_now}) - $signed({1'b0, cand.arrival});
  assign gain_s   = $signed({1'b0, gain});
  assign prod     = wait_val * gain_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= ctrl.cand_valid;
    end
    s_addr       <= cand_addr;
    s_slot_valid <= cand.valid;
    s_prod       <= prod;
    s_sev        <= cand.severity;
    s_name       <= cand.name;
    s_age        <= counter - cand.order;
  end

  assign pri = PRI_W'(s_prod) + PRI_W'($signed({1'b0, s_sev}));

  always_comb begin
    eligible = 1'b0;
    better   = 1'b0;
    case (req_type)
      REQ_ARRIVE: begin
        // The lowest free slot wins.
        eligible = !s_slot_valid;
        better   = !have;
      end
      REQ_SERVE: begin
        eligible = s_slot_valid;
        better   = !have || (pri > best_pri) ||
                   (pri == best_pri && (s_name < best_name ||
                    (s_name == best_name && s_age > best_age)));
      end
      REQ_LEAVE: begin
        eligible = s_slot_valid && (s_name == req_name);
        better   = !have || (s_age > best_age);
      end
      default: begin
        eligible = 1'b0;
        better   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctrl.clear) begin
      have <= 1'b0;
    end else if (s_valid && eligible && better) begin
      have <= 1'b1;
    end
    if (s_valid && eligible && better) begin
      best_pri  <= pri;
      best_name <= s_name;
      best_age  <= s_age;
      best_addr <= s_addr;
    end
  end

  assign res.found = have;
  assign res.busy  = s_valid;
  assign res.name  = best_name;

endmodule

FILE: design/aging_priority_queue.sv
// Top level of the aging priority queue: sequencer, slot memory and evaluation unit.
//
// A request is accepted on a rising edge with start high and busy low. Arrive
// stores the entry in the lowest free slot, serve removes the slot with the
// highest aged priority (severity + gain * waiting time, ties to the smaller
// name and then the earlier arrival), and leave removes the earliest arrival
// with the given name.
// Every request gives one result, shown on rsp for a single cycle with done
// high; the receiver cannot hold it off, so it must take it in that cycle.
// Arrive, serve and leave each sweep the whole slot memory, one slot a cycle
// through the shared multiply and compare unit, wait for the last slot to
// leave the comparator and then write; busy falls as done rises.
// An unknown request type skips the sweep and goes straight to the write state.
// The gain register is written through cfg_valid/cfg_ready/cfg_data at any
// time; cfg_ready is always high, and writes are meant for idle periods.
// After reset the block clears every slot of the slot memory, with busy high;
// the gain and the arrival counter reset to zero.
module aging_priority_queue
  import apq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GAIN_W-1:0] cfg_data,
  output logic              done,
  output rsp_t              rsp
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  state_t             state;
  state_t             state_next;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      addr_next;
  logic               last;
  logic               rd_valid;
  logic [AW-1:0]      rd_addr;
  logic [GAIN_W-1:0]  aging_gain;
  logic [ORDER_W-1:0] arrival_counter;
  req_t               req_q;

  logic               issue;
  logic               emit;
  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  entry_t             rdata;
  logic               stored;
  rsp_t               rsp_next;

  eval_ctrl_t         ctrl;
  eval_res_t          res;
  logic [AW-1:0]      best_addr;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign last      = (addr == AW'(QUEUE_DEPTH - 1));

  apq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  apq_eval #(
    .AW (AW)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .req_type  (req_q.req_type),
    .time_now  (req_q.time_now),
    .req_name  (req_q.name_code),
    .gain      (aging_gain),
    .counter   (arrival_counter),
    .cand_addr (rd_addr),
    .cand      (rdata),
    .res       (res),
    .best_addr (best_addr)
  );

  assign ctrl.clear      = (state == S_IDLE) && start;
  assign ctrl.cand_valid = rd_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req.req_type == REQ_ARRIVE || req.req_type == REQ_SERVE ||
              req.req_type == REQ_LEAVE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Wait until the last slot has passed the comparator.
        if (!rd_valid && !res.busy) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    issue    = 1'b0;
    emit     = 1'b0;
    we       = 1'b0;
    waddr    = best_addr;
    wdata    = '0;
    stored   = 1'b0;
    addr_next = '0;
    rsp_next = '{status: ST_NOTFOUND, served_name: '0};
    case (state)
      S_CLEAR: begin
        we        = 1'b1;
        waddr     = addr;
        addr_next = last ? '0 : addr + AW'(1);
      end
      S_SCAN: begin
        issue     = 1'b1;
        addr_next = last ? '0 : addr + AW'(1);
      end
      S_WRITE: begin
        emit = 1'b1;
        case (req_q.req_type)
          REQ_ARRIVE: begin
            if (res.found) begin
              we       = 1'b1;
              stored   = 1'b1;
              wdata    = '{valid: 1'b1, arrival: req_q.time_now,
                           severity: req_q.severity, name: req_q.name_code,
                           order: arrival_counter};
              rsp_next.status = ST_STORED;
            end else begin
              rsp_next.status = ST_DROPPED;
            end
          end
          REQ_SERVE: begin
            if (res.found) begin
              we = 1'b1;
              rsp_next.status      = ST_SERVED;
              rsp_next.served_name = res.name;
            end else begin
              rsp_next.status = ST_EMPTY;
            end
          end
          REQ_LEAVE: begin
            if (res.found) begin
              we = 1'b1;
              rsp_next.status = ST_LEFT;
            end else begin
              rsp_next.status = ST_NOTFOUND;
            end
          end
          default: begin
            rsp_next.status = ST_NOTFOUND;
          end
        endcase
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      addr            <= '0;
      rd_valid        <= 1'b0;
      done            <= 1'b0;
      aging_gain      <= '0;
      arrival_counter <= '0;
    end else begin
      state    <= state_next;
      addr     <= addr_next;
      rd_valid <= issue;
      done     <= emit;
      if (cfg_valid && cfg_ready) begin
        aging_gain <= cfg_data;
      end
      if (stored) begin
        arrival_counter <= arrival_counter + ORDER_W'(1);
      end
    end
    rd_addr <= addr;
    if (start && !busy) begin
      req_q <= req;
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: design/apq_checker.sv
// Port-level checker for the aging priority queue, bound to the top level.
module apq_checker
  import apq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  // A result always closes a request that kept the block busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Only a served result carries a name.
  a_name_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_SERVED) |-> (rsp.served_name == '0))
    else $error("name reported on a result that is not served");

  // The slot memory is being cleared straight after reset.
  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> (busy && !done))
    else $error("block not busy clearing after reset");

endmodule

bind aging_priority_queue apq_checker u_apq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

FILE: bench/apq_response_check.sv
// Response checker for the aging priority queue: predicts each response and compares it.
module apq_response_check
  import apq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  req_t              req,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [GAIN_W-1:0] cfg_data,
  input  logic              done,
  input  rsp_t              rsp,
  output int                mismatch_count,
  output int                rsp_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  // Our own copy of the slot store, the arrival stamp counter and the gain.
  logic               held          [QUEUE_DEPTH];
  logic [TIME_W-1:0]  held_arrival  [QUEUE_DEPTH];
  logic [SEV_W-1:0]   held_severity [QUEUE_DEPTH];
  logic [NAME_W-1:0]  held_name     [QUEUE_DEPTH];
  logic [ORDER_W-1:0] held_stamp    [QUEUE_DEPTH];
  logic [ORDER_W-1:0] stamp_next;
  logic [GAIN_W-1:0]  gain;

  rsp_t awaited_rsp[$];
  rsp_t want_rsp;

  initial begin
    mismatch_count  = 0;
    rsp_outstanding = 0;
  end

  task automatic flag_mismatch(input string what);
    // Past the cap the count still grows, so the verdict is unaffected.
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Priority after waiting; the wait is negative when t is before arrival.
  function automatic longint aged_priority(int k, logic [TIME_W-1:0] t);
    longint waited;
    longint sev;
    longint g;
    waited = longint'(t);
    waited = waited - longint'(held_arrival[k]);
    sev    = longint'(held_severity[k]);
    g      = longint'(gain);
    return sev + waited * g;
  endfunction

  // Wrapped age of a slot: larger means it arrived earlier.
  function automatic logic [ORDER_W-1:0] age_of_slot(int k);
    return stamp_next - held_stamp[k];
  endfunction

  function automatic rsp_t queue_response(req_t r);
    rsp_t   res;
    int     pick;
    longint top_pri;
    longint p;
    res.status      = ST_NOTFOUND;
    res.served_name = '0;
    pick    = -1;
    top_pri = 0;
    case (r.req_type)
      REQ_ARRIVE: begin
        for (int k = 0; k < QUEUE_DEPTH && pick < 0; k++) begin
          if (!held[k]) pick = k;
        end
        if (pick >= 0) begin
          held[pick]          = 1'b1;
          held_arrival[pick]  = r.time_now;
          held_severity[pick] = r.severity;
          held_name[pick]     = r.name_code;
          held_stamp[pick]    = stamp_next;
          stamp_next          = stamp_next + ORDER_W'(1);
          res.status          = ST_STORED;
        end else begin
          res.status = ST_DROPPED;
        end
      end
      REQ_SERVE: begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
          if (held[k]) begin
            p = aged_priority(k, r.time_now);
            if (pick < 0 || p > top_pri ||
                (p == top_pri && (held_name[k] < held_name[pick] ||
                 (held_name[k] == held_name[pick] &&
                  age_of_slot(k) > age_of_slot(pick))))) begin
              pick    = k;
              top_pri = p;
            end
          end
        end
        if (pick >= 0) begin
          held[pick]      = 1'b0;
          res.status      = ST_SERVED;
          res.served_name = held_name[pick];
        end else begin
          res.status = ST_EMPTY;
        end
      end
      REQ_LEAVE: begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
          if (held[k] && held_name[k] == r.name_code) begin
            if (pick < 0 || age_of_slot(k) > age_of_slot(pick)) pick = k;
          end
        end
        if (pick >= 0) begin
          held[pick] = 1'b0;
          res.status = ST_LEFT;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) held[k] = 1'b0;
      stamp_next = '0;
      gain       = '0;
      awaited_rsp.delete();
    end else begin
      if (cfg_valid && cfg_ready) gain = cfg_data;
      // A response and a new request can share an edge; the response is the older one.
      if (done) begin
        if (awaited_rsp.size() == 0) begin
          flag_mismatch("response with no request outstanding");
        end else begin
          want_rsp = awaited_rsp.pop_front();
          if (rsp.status !== want_rsp.status) begin
            flag_mismatch($sformatf("status %0d, expected %0d",
                                    rsp.status, want_rsp.status));
          end
          if (rsp.served_name !== want_rsp.served_name) begin
            flag_mismatch($sformatf("served_name %0h, expected %0h",
                                    rsp.served_name, want_rsp.served_name));
          end
        end
      end
      if (start && !busy) awaited_rsp = {awaited_rsp, queue_response(req)};
    end
    rsp_outstanding = awaited_rsp.size();
  end

endmodule

FILE: bench/tb_aging_priority_queue.sv
// Testbench top for the aging priority queue: stimulus, gain settings and verdict.
module tb_aging_priority_queue
  import apq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          QD          = DEFAULT_QUEUE_DEPTH;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          POOL_N      = 8;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [63:0] NAME_TOP    = 64'd205891132094648;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [SEV_W-1:0]  SEV_TOP  = '1;
  localparam logic [GAIN_W-1:0] GAIN_TOP = '1;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  req_t              req;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [GAIN_W-1:0] cfg_data;
  logic              done;
  rsp_t              rsp;
  int                mismatch_count;
  int                rsp_outstanding;
  int                cycle_count = 0;

  logic [NAME_W-1:0] name_pool [POOL_N];
  logic [TIME_W-1:0] clock_now;

  always #1 clk = ~clk;

  aging_priority_queue #(.QUEUE_DEPTH(QD)) dut (
    .clk, .rst, .start, .busy, .req, .cfg_valid, .cfg_ready, .cfg_data, .done, .rsp
  );

  apq_response_check #(.QUEUE_DEPTH(QD)) response_check (
    .clk, .rst, .start, .busy, .req, .cfg_valid, .cfg_ready, .cfg_data, .done, .rsp,
    .mismatch_count, .rsp_outstanding
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("aging_priority_queue test failed");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [TIME_W-1:0] t,
                                    input logic [NAME_W-1:0] nm,
                                    input logic [SEV_W-1:0] sv);
    req_t r;
    r.req_type  = kind;
    r.time_now  = t;
    r.name_code = nm;
    r.severity  = sv;
    return r;
  endfunction

  // Mostly names from a small pool, so that leaves and ties find matches.
  function automatic logic [NAME_W-1:0] pick_name();
    logic [63:0] wide;
    if ($urandom_range(0, 99) < 65) return name_pool[$urandom_range(0, POOL_N - 1)];
    wide = {$urandom, $urandom};
    return NAME_W'(wide % (NAME_TOP + 1));
  endfunction

  // Time moves forward slowly; now and then a wild value gives negative waits.
  function automatic logic [TIME_W-1:0] pick_time();
    clock_now = clock_now + TIME_W'($urandom_range(0, 40));
    if ($urandom_range(0, 99) < 15) return TIME_W'($urandom);
    return clock_now;
  endfunction

  function automatic req_t random_request(input int arrive_pct);
    req_t r;
    int   roll;
    r.time_now  = pick_time();
    r.name_code = pick_name();
    r.severity  = ($urandom_range(0, 1) != 0) ? SEV_W'($urandom_range(0, 2000))
                                               : SEV_W'($urandom);
    if ($urandom_range(0, 99) < arrive_pct) begin
      r.req_type = REQ_ARRIVE;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) r.req_type = REQ_UNUSED;
      else if (roll < 80) r.req_type = REQ_SERVE;
      else r.req_type = REQ_LEAVE;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic issue_request(input req_t r);
    start <= 1'b1;
    req   <= r;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    if ($urandom_range(0, 99) < 30) begin
      // Half the pauses begin only once the block has just gone idle.
      if ($urandom_range(0, 1) != 0) begin
        while (busy) @(negedge clk);
      end
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (rsp_outstanding != 0 || busy) @(negedge clk);
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] g);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int arrive_pct, input bit idle_on);
    for (int i = 0; i < n; i++) begin
      issue_request(random_request(arrive_pct));
      if (idle_on) pause_sender();
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    clock_now = TIME_W'($urandom);
    name_pool[0] = '0;
    name_pool[1] = NAME_W'(NAME_TOP);
    for (int i = 2; i < POOL_N; i++) name_pool[i] = NAME_W'({$urandom, $urandom} % NAME_TOP);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The drain inside set_gain also waits out the slot clearing after reset.
    set_gain(GAIN_TOP);

    // Empty store, an unknown request code and a leave for an absent name.
    issue_request(make_req(REQ_SERVE, TIME_W'(5), NAME_W'(NAME_TOP), SEV_TOP));
    issue_request(make_req(REQ_LEAVE, TIME_TOP, NAME_W'(7), SEV_TOP));
    issue_request(make_req(REQ_UNUSED, TIME_TOP, NAME_W'(NAME_TOP), SEV_TOP));
    // Field extremes. Served at time 0, the first entry has waited a negative time,
    // and once alone it must still be served despite its negative priority.
    issue_request(make_req(REQ_ARRIVE, TIME_TOP, NAME_W'(NAME_TOP), SEV_TOP));
    issue_request(make_req(REQ_ARRIVE, '0, '0, '0));
    issue_request(make_req(REQ_SERVE, '0, '0, '0));
    issue_request(make_req(REQ_SERVE, '0, '0, '0));
    // Equal priorities: the smaller name wins, then the earlier arrival.
    issue_request(make_req(REQ_ARRIVE, TIME_W'(100), NAME_W'(500), SEV_W'(10)));
    issue_request(make_req(REQ_ARRIVE, TIME_W'(100), NAME_W'(500), SEV_W'(10)));
    issue_request(make_req(REQ_ARRIVE, TIME_W'(100), NAME_W'(300), SEV_W'(10)));
    issue_request(make_req(REQ_ARRIVE, TIME_W'(100), NAME_W'(500), SEV_W'(10)));
    issue_request(make_req(REQ_SERVE, TIME_W'(200), '0, '0));
    issue_request(make_req(REQ_LEAVE, TIME_TOP, NAME_W'(500), SEV_TOP));
    issue_request(make_req(REQ_LEAVE, '0, NAME_W'(999), '0));
    issue_request(make_req(REQ_SERVE, TIME_W'(100), NAME_W'(NAME_TOP), '0));
    issue_request(make_req(REQ_SERVE, TIME_W'(100), '0, SEV_TOP));
    issue_request(make_req(REQ_SERVE, TIME_W'(100), '0, '0));
    // Severity against waiting time at full gain.
    issue_request(make_req(REQ_ARRIVE, TIME_W'(1000), NAME_W'(60), '0));
    issue_request(make_req(REQ_ARRIVE, TIME_W'(1001), NAME_W'(50), SEV_TOP));
    issue_request(make_req(REQ_SERVE, TIME_W'(1001), '0, '0));
    issue_request(make_req(REQ_SERVE, TIME_W'(2000), '0, '0));

    set_gain('0);
    run_phase(150, 50, 1'b1);
    set_gain(GAIN_TOP);
    run_phase(150, 50, 1'b1);
    // Arrival-heavy: the store fills up and arrivals get dropped.
    set_gain(GAIN_W'(1));
    run_phase(330, 92, 1'b1);
    // Serve-heavy: the store empties again and serves hit an empty store.
    set_gain(GAIN_W'($urandom));
    run_phase(400, 8, 1'b1);
    set_gain(GAIN_W'($urandom_range(2, 64)));
    run_phase(100, 50, 1'b0);

    drain();
    repeat (QD + 8) @(negedge clk);
    if (mismatch_count == 0 && rsp_outstanding == 0) begin
      $display("aging_priority_queue test passed");
    end else begin
      $display("aging_priority_queue test failed");
    end
    $finish;
  end

endmodule

FILE: aging_priority_queue.f
design/apq_pkg.sv
design/apq_ram.sv
design/apq_eval.sv
design/aging_priority_queue.sv
design/apq_checker.sv
bench/apq_response_check.sv
bench/tb_aging_priority_queue.sv
